>>> hdl/assert_macros.svh
// assertion macros used by the top-level rtl file of the relative rotation block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RRQ_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define RRQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RRQ_ASSERT(lbl, clk, rstn, prop, msg)
`define RRQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> hdl/rrq_pkg.sv
// package: widths, types and rounding helpers of the relative rotation block
`timescale 1ns / 1ps
`default_nettype none
package rrq_pkg;
	localparam int FRAC   = 14;
	localparam int IN_W   = 16;
	localparam int OUT_W  = 16;
	localparam int PROD_W = 2 * IN_W;
	// exact quaternion-to-matrix terms, wide enough for the constant one at 2*FRAC bits
	localparam int QM_W   = (2 * FRAC + 2 > PROD_W + 3) ? 2 * FRAC + 2 : PROD_W + 3;
	// matrix element after rounding to FRAC fraction bits
	localparam int QE_W   = QM_W - FRAC + 1;
	localparam int PR_W   = 2 * QE_W;
	localparam int AC_W   = PR_W + 2;

	localparam logic signed [QM_W-1:0] ONE_M =
		{{(QM_W-2*FRAC-1){1'b0}}, 1'b1, {(2*FRAC){1'b0}}};
	localparam logic signed [QM_W-1:0] HALF_M =
		{{(QM_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
	localparam logic signed [AC_W-1:0] HALF_A =
		{{(AC_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
	localparam logic signed [AC_W-1:0] SAT_HI =
		{{(AC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
	localparam logic signed [AC_W-1:0] SAT_LO =
		{{(AC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

	// frame swap of rows/columns 0 and 1
	localparam int PERM [3] = '{1, 0, 2};

	typedef logic signed [IN_W-1:0] comp_t;
	typedef logic signed [QE_W-1:0] elem_t;
	typedef elem_t [2:0][2:0] mat_t;
	typedef logic [2:0][2:0][OUT_W-1:0] omat_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

	// round half up to FRAC fraction bits
	function automatic elem_t round_el(input logic signed [QM_W-1:0] v);
		logic signed [QM_W-1:0] t;
		t = v + HALF_M;
		t = t >>> FRAC;
		return t[QE_W-1:0];
	endfunction

	// optional negate, round half up, saturate to the output width
	function automatic logic [OUT_W-1:0] sat_round(input logic signed [AC_W-1:0] acc,
			input logic flip);
		logic signed [AC_W-1:0] t;
		logic [OUT_W-1:0] r;
		t = flip ? -acc : acc;
		t = t + HALF_A;
		t = t >>> FRAC;
		if (t > SAT_HI) begin
			r = SAT_HI[OUT_W-1:0];
		end else if (t < SAT_LO) begin
			r = SAT_LO[OUT_W-1:0];
		end else begin
			r = t[OUT_W-1:0];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

>>> hdl/rrq_in_if.sv
// interface: input channel carrying the reference and imu quaternions
`timescale 1ns / 1ps
`default_nettype none
interface rrq_in_if;
	logic valid;
	logic ready;
	logic signed [rrq_pkg::IN_W-1:0] ref_w;
	logic signed [rrq_pkg::IN_W-1:0] ref_x;
	logic signed [rrq_pkg::IN_W-1:0] ref_y;
	logic signed [rrq_pkg::IN_W-1:0] ref_z;
	logic signed [rrq_pkg::IN_W-1:0] imu_w;
	logic signed [rrq_pkg::IN_W-1:0] imu_x;
	logic signed [rrq_pkg::IN_W-1:0] imu_y;
	logic signed [rrq_pkg::IN_W-1:0] imu_z;

	modport source(output valid, ref_w, ref_x, ref_y, ref_z, imu_w, imu_x, imu_y, imu_z,
		input ready);
	modport sink(input valid, ref_w, ref_x, ref_y, ref_z, imu_w, imu_x, imu_y, imu_z,
		output ready);
endinterface
`default_nettype wire

>>> hdl/rrq_out_if.sv
// interface: output channel carrying the nine relative rotation elements
`timescale 1ns / 1ps
`default_nettype none
interface rrq_out_if;
	logic valid;
	logic ready;
	logic signed [rrq_pkg::OUT_W-1:0] r00;
	logic signed [rrq_pkg::OUT_W-1:0] r01;
	logic signed [rrq_pkg::OUT_W-1:0] r02;
	logic signed [rrq_pkg::OUT_W-1:0] r10;
	logic signed [rrq_pkg::OUT_W-1:0] r11;
	logic signed [rrq_pkg::OUT_W-1:0] r12;
	logic signed [rrq_pkg::OUT_W-1:0] r20;
	logic signed [rrq_pkg::OUT_W-1:0] r21;
	logic signed [rrq_pkg::OUT_W-1:0] r22;

	modport source(output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		input ready);
	modport sink(input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
		output ready);
endinterface
`default_nettype wire

>>> hdl/rrq_quat_mat.sv
// quaternion to rotation matrix, two pipeline stages: products, then sums and rounding
`timescale 1ns / 1ps
`default_nettype none
module rrq_quat_mat (
	input  logic               clk,
	input  rrq_pkg::stage_en_t en,
	input  rrq_pkg::comp_t     w,
	input  rrq_pkg::comp_t     x,
	input  rrq_pkg::comp_t     y,
	input  rrq_pkg::comp_t     z,
	output rrq_pkg::mat_t      m_s2
);
	import rrq_pkg::*;

	logic signed [PROD_W-1:0] xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;

	// stage 1: the nine distinct component products
	always_ff @(posedge clk) begin
		if (en.s1) begin
			xx_s1 <= x * x;
			yy_s1 <= y * y;
			zz_s1 <= z * z;
			xy_s1 <= x * y;
			xz_s1 <= x * z;
			yz_s1 <= y * z;
			wx_s1 <= w * x;
			wy_s1 <= w * y;
			wz_s1 <= w * z;
		end
	end

	// stage 2: diagonal and off-diagonal terms, rounded to element precision
	always_ff @(posedge clk) begin
		if (en.s2) begin
			m_s2[0][0] <= round_el(ONE_M - ((QM_W'(yy_s1) + QM_W'(zz_s1)) <<< 1));
			m_s2[0][1] <= round_el((QM_W'(xy_s1) - QM_W'(wz_s1)) <<< 1);
			m_s2[0][2] <= round_el((QM_W'(xz_s1) + QM_W'(wy_s1)) <<< 1);
			m_s2[1][0] <= round_el((QM_W'(xy_s1) + QM_W'(wz_s1)) <<< 1);
			m_s2[1][1] <= round_el(ONE_M - ((QM_W'(xx_s1) + QM_W'(zz_s1)) <<< 1));
			m_s2[1][2] <= round_el((QM_W'(yz_s1) - QM_W'(wx_s1)) <<< 1);
			m_s2[2][0] <= round_el((QM_W'(xz_s1) - QM_W'(wy_s1)) <<< 1);
			m_s2[2][1] <= round_el((QM_W'(yz_s1) + QM_W'(wx_s1)) <<< 1);
			m_s2[2][2] <= round_el(ONE_M - ((QM_W'(xx_s1) + QM_W'(yy_s1)) <<< 1));
		end
	end
endmodule
`default_nettype wire

>>> hdl/rrq_mat_mul.sv
// product imu * ref transpose with frame conjugation: products, then sums and saturation
`timescale 1ns / 1ps
`default_nettype none
module rrq_mat_mul (
	input  logic               clk,
	input  rrq_pkg::stage_en_t en,
	input  rrq_pkg::mat_t      ri,
	input  rrq_pkg::mat_t      rr,
	output rrq_pkg::omat_t     res_s4
);
	import rrq_pkg::*;

	logic signed [PR_W-1:0] prod_s3 [3][3][3];

	// stage 3: 27 element products, rows and columns already permuted
	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int k = 0; k < 3; k++) begin
						prod_s3[i][j][k] <= $signed(ri[PERM[i]][k]) * $signed(rr[PERM[j]][k]);
					end
				end
			end
		end
	end

	// stage 4: three-term sum, sign flip where one index is the z axis, round, saturate
	always_ff @(posedge clk) begin
		if (en.s4) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					res_s4[i][j] <= sat_round(AC_W'(prod_s3[i][j][0]) + AC_W'(prod_s3[i][j][1])
						+ AC_W'(prod_s3[i][j][2]), (i == 2) != (j == 2));
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> hdl/relative_rotation_from_quats_top.sv
// top level: relative rotation matrix of an imu pose against a reference pose
//
// channel   dir  handshake      payload
// quat_in   in   valid/ready    ref_w..ref_z, imu_w..imu_z (signed Q2.14)
// mat_out   out  valid/ready    r00..r22 (signed Q2.14, saturated)
//
// four register stages: component products, rounded matrices, element products,
// sums with rounding and saturation; the last stage is the output register
// one transaction per cycle sustained while the output is not stalled; an accepted
// transaction moves through stages 1 to 4, and the stage 4 valid bit drives valid
// each stage holds one multiply or one add tree
// a stall at the output holds the last stage; earlier stages keep filling until full
// reset clears only the stage valid bits
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module relative_rotation_from_quats_top (
	input  logic clk,
	input  logic arst_n,
	rrq_in_if.sink    quat_in,
	rrq_out_if.source mat_out
);
	import rrq_pkg::*;

	stage_en_t en;
	logic      v_s1, v_s2, v_s3, v_s4;
	mat_t      rr_s2, ri_s2;
	omat_t     res_s4;

	// a stage loads when empty or when the stage after it moves
	always_comb begin
		en.s4 = !v_s4 || mat_out.ready;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign quat_in.ready = en.s1;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= quat_in.valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
		end
	end

	// reference and imu matrices
	rrq_quat_mat u_ref_mat (
		.clk  (clk),
		.en   (en),
		.w    (quat_in.ref_w),
		.x    (quat_in.ref_x),
		.y    (quat_in.ref_y),
		.z    (quat_in.ref_z),
		.m_s2 (rr_s2)
	);

	rrq_quat_mat u_imu_mat (
		.clk  (clk),
		.en   (en),
		.w    (quat_in.imu_w),
		.x    (quat_in.imu_x),
		.y    (quat_in.imu_y),
		.z    (quat_in.imu_z),
		.m_s2 (ri_s2)
	);

	// relative rotation in the swapped frame
	rrq_mat_mul u_mat_mul (
		.clk    (clk),
		.en     (en),
		.ri     (ri_s2),
		.rr     (rr_s2),
		.res_s4 (res_s4)
	);

	// output channel
	assign mat_out.valid = v_s4;
	assign mat_out.r00   = res_s4[0][0];
	assign mat_out.r01   = res_s4[0][1];
	assign mat_out.r02   = res_s4[0][2];
	assign mat_out.r10   = res_s4[1][0];
	assign mat_out.r11   = res_s4[1][1];
	assign mat_out.r12   = res_s4[1][2];
	assign mat_out.r20   = res_s4[2][0];
	assign mat_out.r21   = res_s4[2][1];
	assign mat_out.r22   = res_s4[2][2];

	// checks on the stage control
	`RRQ_ASSERT(a_accept_fills_s1, clk, arst_n, (quat_in.valid && quat_in.ready) |=> v_s1, "accepted transaction did not enter stage 1")
	`RRQ_ASSERT(a_s3_moves_out, clk, arst_n, (v_s3 && en.s4) |=> mat_out.valid, "stage 3 transaction did not reach the output")
	`RRQ_ASSERT(a_stall_only_full, clk, arst_n, !quat_in.ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && !mat_out.ready), "input stalled with a free stage")
endmodule
`default_nettype wire

>>> sim/tb_top.sv
// testbench for the relative rotation block: randomised quaternion pairs checked against a matrix predictor
`timescale 1ns / 1ps
module tb_top;
	import rrq_pkg::*;

	localparam int RANDOM_PAIRS = 650;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 8;
	localparam int REPORT_CAP   = 10;
	localparam logic signed [IN_W-1:0] C_MAX = 16'sh7fff;
	localparam logic signed [IN_W-1:0] C_MIN = 16'sh8000;
	localparam logic signed [IN_W-1:0] C_ONE = 16'sh4000;
	localparam logic signed [IN_W-1:0] C_NEG = -16'sh4000;

	typedef struct packed {
		comp_t w;
		comp_t x;
		comp_t y;
		comp_t z;
	} quat_t;

	typedef struct packed {
		quat_t ref_q;
		quat_t imu_q;
	} quat_pair_t;

	// fifo of predicted rotation matrices, compared in order against the output
	class rotation_scoreboard;
		omat_t expected_mats[$];
		int    faults;
		int    checked;

		function new();
			faults  = 0;
			checked = 0;
		endfunction

		// round half up to the fraction width
		function longint round_q(longint v);
			return (v + (longint'(1) << (FRAC - 1))) >>> FRAC;
		endfunction

		// unit-quaternion formula, each element rounded to the fraction width
		function void quat_matrix(quat_t q, output longint m[3][3]);
			longint w, x, y, z, one;
			w = $signed(q.w);
			x = $signed(q.x);
			y = $signed(q.y);
			z = $signed(q.z);
			one = longint'(1) << (2 * FRAC);
			m[0][0] = round_q(one - 2 * (y * y + z * z));
			m[0][1] = round_q(2 * (x * y - w * z));
			m[0][2] = round_q(2 * (x * z + w * y));
			m[1][0] = round_q(2 * (x * y + w * z));
			m[1][1] = round_q(one - 2 * (x * x + z * z));
			m[1][2] = round_q(2 * (y * z - w * x));
			m[2][0] = round_q(2 * (x * z - w * y));
			m[2][1] = round_q(2 * (y * z + w * x));
			m[2][2] = round_q(one - 2 * (x * x + y * y));
		endfunction

		// imu matrix times transposed reference, conjugated by the frame swap
		function omat_t relative_rotation(quat_pair_t p);
			longint rr[3][3];
			longint ri[3][3];
			longint acc, v;
			int a, b;
			omat_t res;
			quat_matrix(p.ref_q, rr);
			quat_matrix(p.imu_q, ri);
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					a = PERM[i];
					b = PERM[j];
					acc = 0;
					for (int k = 0; k < 3; k++) begin
						acc += ri[a][k] * rr[b][k];
					end
					// z axis flips sign; applied before saturation
					if ((i == 2) != (j == 2)) begin
						acc = -acc;
					end
					v = round_q(acc);
					if (v > 32767) begin
						v = 32767;
					end else if (v < -32768) begin
						v = -32768;
					end
					res[i][j] = v[OUT_W-1:0];
				end
			end
			return res;
		endfunction

		function void note_quats(quat_pair_t p);
			expected_mats.push_back(relative_rotation(p));
		endfunction

		function void check_matrix(omat_t got);
			omat_t want;
			if (expected_mats.size() == 0) begin
				faults++;
				if (faults <= REPORT_CAP) begin
					$display("tb_top: result transaction with nothing outstanding");
				end
				return;
			end
			want = expected_mats.pop_front();
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (got[i][j] !== want[i][j]) begin
						faults++;
						if (faults <= REPORT_CAP) begin
							$display("tb_top: transaction %0d r%0d%0d expected %0d got %0d",
								checked, i, j, $signed(want[i][j]), $signed(got[i][j]));
						end
					end
				end
			end
			checked++;
		endfunction

		function int pending();
			return expected_mats.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   idle_cycles = 0;
	int   src_calm = 0;
	int   sink_calm = 0;
	int   sink_hold = 0;
	rotation_scoreboard sb;

	rrq_in_if  quat_in();
	rrq_out_if mat_out();

	relative_rotation_from_quats_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.quat_in (quat_in),
		.mat_out (mat_out)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then long, with calm stretches
	function automatic int pick_idle(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic quat_t mk_quat(int w, int x, int y, int z);
		quat_t q;
		q.w = comp_t'(w);
		q.x = comp_t'(x);
		q.y = comp_t'(y);
		q.z = comp_t'(z);
		return q;
	endfunction

	// random direction on the unit sphere, scaled to Q2.14
	function automatic quat_t rand_unit();
		real a[4];
		real n;
		quat_t q;
		do begin
			for (int k = 0; k < 4; k++) begin
				a[k] = real'(int'($urandom_range(0, 20000)) - 10000) / 10000.0;
			end
			n = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
		end while (n < 0.1);
		q.w = comp_t'(int'(a[0] * 16384.0 / n));
		q.x = comp_t'(int'(a[1] * 16384.0 / n));
		q.y = comp_t'(int'(a[2] * 16384.0 / n));
		q.z = comp_t'(int'(a[3] * 16384.0 / n));
		return q;
	endfunction

	function automatic quat_t rand_in_range();
		return mk_quat(int'($urandom_range(0, 32768)) - 16384,
			int'($urandom_range(0, 32768)) - 16384,
			int'($urandom_range(0, 32768)) - 16384,
			int'($urandom_range(0, 32768)) - 16384);
	endfunction

	function automatic quat_t rand_raw();
		return mk_quat($urandom, $urandom, $urandom, $urandom);
	endfunction

	// unit quaternion with one component pushed to an extreme
	function automatic quat_t rand_extreme();
		quat_t q;
		comp_t e;
		q = rand_unit();
		case ($urandom_range(0, 3))
			0: e = C_MAX;
			1: e = C_MIN;
			2: e = C_ONE;
			default: e = C_NEG;
		endcase
		case ($urandom_range(0, 3))
			0: q.w = e;
			1: q.x = e;
			2: q.y = e;
			default: q.z = e;
		endcase
		return q;
	endfunction

	// mostly well-formed pose pairs, the rest non-unit, raw and extreme
	function automatic quat_pair_t random_pair();
		quat_pair_t p;
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			p.ref_q = rand_unit();
			p.imu_q = rand_unit();
		end else if (r < 78) begin
			p.ref_q = rand_in_range();
			p.imu_q = rand_in_range();
		end else if (r < 88) begin
			p.ref_q = rand_raw();
			p.imu_q = rand_raw();
		end else if (r < 94) begin
			p.ref_q = $urandom_range(0, 1) ? rand_unit() : rand_raw();
			p.imu_q = $urandom_range(0, 1) ? rand_unit() : rand_raw();
		end else begin
			p.ref_q = $urandom_range(0, 1) ? rand_extreme() : rand_unit();
			p.imu_q = rand_extreme();
		end
		return p;
	endfunction

	// present one pair after a random gap and hold it until accepted
	task automatic push_quats(input quat_t rq, input quat_t iq);
		int gap;
		gap = pick_idle(src_calm);
		if (gap > 0) begin
			quat_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		quat_in.valid <= 1'b1;
		quat_in.ref_w <= rq.w;
		quat_in.ref_x <= rq.x;
		quat_in.ref_y <= rq.y;
		quat_in.ref_z <= rq.z;
		quat_in.imu_w <= iq.w;
		quat_in.imu_x <= iq.x;
		quat_in.imu_y <= iq.y;
		quat_in.imu_z <= iq.z;
		do @(posedge clk); while (!quat_in.ready);
	endtask

	// output back-pressure
	always @(posedge clk) begin
		if (sink_hold == 0) begin
			sink_hold = pick_idle(sink_calm);
		end
		if (sink_hold > 0) begin
			sink_hold--;
			mat_out.ready <= 1'b0;
		end else begin
			mat_out.ready <= 1'b1;
		end
	end

	// transaction monitor and idle watchdog
	always @(posedge clk) begin
		omat_t got;
		got[0][0] = mat_out.r00;
		got[0][1] = mat_out.r01;
		got[0][2] = mat_out.r02;
		got[1][0] = mat_out.r10;
		got[1][1] = mat_out.r11;
		got[1][2] = mat_out.r12;
		got[2][0] = mat_out.r20;
		got[2][1] = mat_out.r21;
		got[2][2] = mat_out.r22;
		if (arst_n && quat_in.valid && quat_in.ready) begin
			sb.note_quats({{quat_in.ref_w, quat_in.ref_x, quat_in.ref_y, quat_in.ref_z},
				{quat_in.imu_w, quat_in.imu_x, quat_in.imu_y, quat_in.imu_z}});
		end
		if (arst_n && mat_out.valid && mat_out.ready) begin
			sb.check_matrix(got);
		end
		if ((quat_in.valid && quat_in.ready) || (mat_out.valid && mat_out.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		quat_in.valid = 1'b0;
		quat_in.ref_w = '0;
		quat_in.ref_x = '0;
		quat_in.ref_y = '0;
		quat_in.ref_z = '0;
		quat_in.imu_w = '0;
		quat_in.imu_x = '0;
		quat_in.imu_y = '0;
		quat_in.imu_z = '0;
		mat_out.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identity, axis turns, non-unit and out-of-range extremes
		push_quats(mk_quat(16384, 0, 0, 0), mk_quat(16384, 0, 0, 0));
		push_quats(mk_quat(16384, 0, 0, 0), mk_quat(11585, 0, 0, 11585));
		push_quats(mk_quat(8192, 8192, 8192, 8192), mk_quat(8192, 8192, 8192, 8192));
		push_quats(mk_quat(0, 16384, 0, 0), mk_quat(0, 0, 16384, 0));
		push_quats(mk_quat(0, 0, 0, 16384), mk_quat(-16384, 0, 0, 0));
		push_quats(mk_quat(0, -16384, 0, 0), mk_quat(0, 0, -16384, 0));
		push_quats(mk_quat(11585, 11585, 0, 0), mk_quat(11585, 0, -11585, 0));
		push_quats(mk_quat(16384, 16384, 16384, 16384), mk_quat(16384, 16384, 16384, 16384));
		push_quats(mk_quat(-16384, -16384, -16384, -16384),
			mk_quat(-16384, -16384, -16384, -16384));
		push_quats(mk_quat(16384, 16384, -16384, 16384), mk_quat(-16384, 16384, 16384, -16384));
		push_quats(mk_quat(32767, 32767, 32767, 32767), mk_quat(32767, 32767, 32767, 32767));
		push_quats(mk_quat(-32768, -32768, -32768, -32768),
			mk_quat(-32768, -32768, -32768, -32768));
		push_quats(mk_quat(32767, -32768, 32767, -32768), mk_quat(-32768, 32767, -32768, 32767));
		push_quats(mk_quat(-32768, 0, 0, 0), mk_quat(0, 32767, 0, 0));
		push_quats(mk_quat(0, 0, 0, 0), mk_quat(0, 0, 0, 0));
		push_quats(mk_quat(0, 0, 0, 0), mk_quat(32767, 32767, 32767, 32767));
		push_quats(mk_quat(16384, 32767, 0, 0), mk_quat(0, 0, -32768, 32767));
		push_quats(mk_quat(0, 32767, 32767, 0), mk_quat(0, -32768, 32767, 0));
		push_quats(mk_quat(1, -1, 1, -1), mk_quat(-1, 1, -1, 1));
		push_quats(mk_quat(181, 181, 0, 0), mk_quat(0, 0, 181, -181));

		for (int n = 0; n < RANDOM_PAIRS; n++) begin
			quat_pair_t p;
			p = random_pair();
			push_quats(p.ref_q, p.imu_q);
		end
		quat_in.valid <= 1'b0;

		// drain, then let the pipeline settle
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.faults == 0 && sb.pending() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end
endmodule
